// ===== src/ssdf_pkg.sv =====
// Shared types and constants for the SPI servo command deframer.
`timescale 1ns / 1ps
package ssdf_pkg;

  // High byte that marks a start word
  localparam logic [7:0] START_MARK = 8'h23;

  // Configuration register indexes (paddr[3:2])
  localparam logic [1:0] REG_IDENTIFY_CODE   = 2'd0;
  localparam logic [1:0] REG_SERVO_MOVE_CODE = 2'd1;
  localparam logic [1:0] REG_IDENT_REPLY     = 2'd2;

  // Configuration reset values
  localparam logic [7:0]  IDENTIFY_CODE_RST   = 8'd1;
  localparam logic [7:0]  SERVO_MOVE_CODE_RST = 8'd2;
  localparam logic [15:0] IDENT_REPLY_RST     = 16'd257;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_REPLY  = 2'd0,
    KIND_BYTE   = 2'd1,
    KIND_REJECT = 2'd2,
    KIND_FULL   = 2'd3
  } kind_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_ONE  = 2'd1,
    ST_READ = 2'd2,
    ST_BYTE = 2'd3
  } state_e;

endpackage

// ===== src/ssdf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module ssdf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 20
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, hold data between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/spi_servo_command_deframer.sv =====
// Top level of the SPI servo command deframer: message store, sequencer, config port.
//
//   Channel   Signals                                       Direction  Handshake
//   input     rx_word_i                                     in         in_valid_i / in_stall_o
//   output    kind_o reply_word_o servo_index_o             out        out_valid_o / out_stall_i
//             servo_byte_o last_o
//   config    psel penable pwrite paddr pwdata prdata pready in/out     APB, pready tied high
//
// A word that yields no result leaves the sequencer idle; one yielding a single result
// (reply, reject, full) is loaded from the ONE state. A servo move emits count byte
// writes: per payload word, one memory read in the READ state, then one BYTE state per
// byte. Output stalls hold the ONE and BYTE states; the output register lets a new word
// be taken while the last result still waits. No clearing pass after reset: the message
// store is only read at words written in the current message.
`timescale 1ns / 1ps
module spi_servo_command_deframer #(
  parameter int MSG_WORDS   = 20,
  parameter int SERVO_BYTES = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input word channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] rx_word_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [15:0] reply_word_o,
  output logic [4:0]  servo_index_o,
  output logic [7:0]  servo_byte_o,
  output logic        last_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ssdf_pkg::*;

  localparam int AW = $clog2(MSG_WORDS);
  localparam int CW = $clog2(MSG_WORDS + 1);
  localparam int IW = $clog2(SERVO_BYTES + 1);

  // Configuration registers
  logic [7:0]  identify_code_q;
  logic [7:0]  servo_move_code_q;
  logic [15:0] ident_reply_q;
  logic        cfg_wr;

  // Sequencer and message state
  state_e         state_q, state_d;
  logic           in_msg_q, in_msg_d;
  logic [CW-1:0]  wcnt_q, wcnt_d;
  logic [7:0]     cmd_q;
  logic [7:0]     cnt_q;
  logic [7:0]     off_q;
  logic [IW-1:0]  idx_q, idx_d;
  kind_e          pend_q, pend_d;

  // Output register
  logic           out_valid_q, out_valid_d;
  kind_e          out_kind_q, out_kind_d;
  logic [15:0]    out_reply_q, out_reply_d;
  logic [4:0]     out_index_q, out_index_d;
  logic [7:0]     out_byte_q, out_byte_d;
  logic           out_last_q, out_last_d;
  logic           out_free;
  logic           out_load;

  // Decode of the incoming word
  logic           in_acc;
  logic           is_start;
  logic           msg_live;
  logic [7:0]     cmd_cur;
  logic [CW-1:0]  wcnt_n;
  logic [8:0]     need_words;
  logic           hit_id;
  logic           hit_move;
  logic           hit_full;
  logic           range_bad;
  logic           end_msg;

  // Memory access
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic           ram_re;
  logic [IW:0]    rd_word;
  logic [AW-1:0]  ram_raddr;
  logic [15:0]    ram_rdata;
  logic [8:0]     byte_pos;
  logic           byte_last;

  // ---------------------------------------------------------------------------
  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      identify_code_q   <= IDENTIFY_CODE_RST;
      servo_move_code_q <= SERVO_MOVE_CODE_RST;
      ident_reply_q     <= IDENT_REPLY_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_IDENTIFY_CODE:   identify_code_q   <= pwdata[7:0];
        REG_SERVO_MOVE_CODE: servo_move_code_q <= pwdata[7:0];
        REG_IDENT_REPLY:     ident_reply_q     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (paddr[3:2])
      REG_IDENTIFY_CODE:   prdata = {24'd0, identify_code_q};
      REG_SERVO_MOVE_CODE: prdata = {24'd0, servo_move_code_q};
      REG_IDENT_REPLY:     prdata = {16'd0, ident_reply_q};
      default:             prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Decode the incoming word against the message held so far
  assign in_acc   = in_valid_i && !in_stall_o;
  assign is_start = (rx_word_i[15:8] == START_MARK);
  assign msg_live = in_msg_q || is_start;
  assign cmd_cur  = in_msg_q ? cmd_q : rx_word_i[7:0];
  assign wcnt_n   = in_msg_q ? wcnt_q + CW'(1) : CW'(1);

  // One less than the words needed: header pair plus ceil(count/2) payload words
  assign need_words = (({1'b0, cnt_q} + 9'd1) >> 1) + 9'd1;
  assign range_bad  = ({1'b0, off_q} + {1'b0, cnt_q}) > 9'(SERVO_BYTES);

  assign hit_id   = (cmd_cur == identify_code_q);
  assign hit_move = (cmd_cur == servo_move_code_q) && (wcnt_n > CW'(2)) &&
                    (9'(wcnt_n) > need_words);
  assign hit_full = (wcnt_n >= CW'(MSG_WORDS));
  assign end_msg  = in_acc && msg_live && (hit_id || hit_move || hit_full);

  // ---------------------------------------------------------------------------
  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && msg_live) begin
          if (hit_id) begin
            state_d = ST_ONE;
          end else if (hit_move) begin
            if (range_bad) begin
              state_d = ST_ONE;
            end else if (cnt_q != 8'd0) begin
              state_d = ST_READ;
            end
          end else if (hit_full) begin
            state_d = ST_ONE;
          end
        end
      end
      ST_ONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        state_d = ST_BYTE;
      end
      ST_BYTE: begin
        if (out_free && byte_last) begin
          state_d = ST_IDLE;
        end else if (out_free && idx_q[0]) begin
          state_d = ST_READ;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer outputs: handshake, memory ports, output register load
  assign out_free  = !out_valid_q || !out_stall_i;
  assign rd_word   = {1'b0, idx_q >> 1} + (IW + 1)'(2);
  assign byte_pos  = {1'b0, off_q} + 9'(idx_q);
  assign byte_last = (9'(idx_q) + 9'd1) == {1'b0, cnt_q};

  always_comb begin
    in_stall_o  = 1'b1;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_re      = 1'b0;
    ram_raddr   = AW'(rd_word);
    out_load    = 1'b0;
    out_kind_d  = out_kind_q;
    out_reply_d = out_reply_q;
    out_index_d = out_index_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        ram_we     = in_valid_i;
        ram_waddr  = in_msg_q ? wcnt_q[AW-1:0] : '0;
      end
      ST_ONE: begin
        out_load    = out_free;
        out_kind_d  = pend_q;
        out_reply_d = (pend_q == KIND_REPLY) ? ident_reply_q : 16'd0;
        out_index_d = 5'd0;
        out_byte_d  = 8'd0;
        out_last_d  = 1'b1;
      end
      ST_READ: begin
        ram_re = 1'b1;
      end
      ST_BYTE: begin
        out_load    = out_free;
        out_kind_d  = KIND_BYTE;
        out_reply_d = 16'd0;
        out_index_d = byte_pos[4:0];
        out_byte_d  = idx_q[0] ? ram_rdata[15:8] : ram_rdata[7:0];
        out_last_d  = byte_last;
      end
      default: ;
    endcase
  end

  // Message bookkeeping
  always_comb begin
    in_msg_d = in_msg_q;
    wcnt_d   = wcnt_q;
    idx_d    = idx_q;
    pend_d   = pend_q;
    if (in_acc) begin
      in_msg_d = msg_live && !end_msg;
      wcnt_d   = (msg_live && !end_msg) ? wcnt_n : '0;
      idx_d    = '0;
      pend_d   = hit_id ? KIND_REPLY : (hit_move ? KIND_REJECT : KIND_FULL);
    end else if (state_q == ST_BYTE && out_free) begin
      idx_d = idx_q + IW'(1);
    end
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_msg_q    <= 1'b0;
      wcnt_q      <= '0;
      idx_q       <= '0;
      pend_q      <= KIND_REPLY;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_msg_q    <= in_msg_d;
      wcnt_q      <= wcnt_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Header and result payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc && !in_msg_q) begin
      cmd_q <= rx_word_i[7:0];
    end
    if (in_acc && in_msg_q && wcnt_q == CW'(1)) begin
      cnt_q <= rx_word_i[7:0];
      off_q <= rx_word_i[15:8];
    end
    if (out_load) begin
      out_kind_q  <= out_kind_d;
      out_reply_q <= out_reply_d;
      out_index_q <= out_index_d;
      out_byte_q  <= out_byte_d;
      out_last_q  <= out_last_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Message store
  ssdf_ram #(
    .WIDTH (16),
    .DEPTH (MSG_WORDS)
  ) u_msg_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (rx_word_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign kind_o        = out_kind_q;
  assign reply_word_o  = out_reply_q;
  assign servo_index_o = out_index_q;
  assign servo_byte_o  = out_byte_q;
  assign last_o        = out_last_q;

  // ---------------------------------------------------------------------------
  // Assertions

  // An open message always holds at least the start word and never fills up
  a_wcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_msg_q |-> (wcnt_q != '0) && (wcnt_q < CW'(MSG_WORDS)))
    else $error("word count out of range while a message is open");

  // The byte burst never runs past the header count
  a_idx_below_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BYTE) |-> (9'(idx_q) < {1'b0, cnt_q}))
    else $error("byte index beyond header count");

  // Payload reads stay inside the message store
  a_read_in_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> (32'(rd_word) < MSG_WORDS))
    else $error("payload read outside the message store");

  // A byte result is loaded only from freshly read payload data
  a_byte_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BYTE) && !idx_q[0] |-> $past(state_q == ST_READ) || $past(state_q == ST_BYTE))
    else $error("byte emitted without a payload read");

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the SPI servo command deframer.
`timescale 1ns / 1ps
module tb;
  import ssdf_pkg::*;

  localparam int MSG_WORDS     = 20;
  localparam int SERVO_BYTES   = 24;
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_LIMIT    = 4000;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] reply;
    logic [4:0]  servo_idx;
    logic [7:0]  servo_val;
    logic        last;
  } deframe_result_t;

  // Predicts deframer results per received word and checks what comes out
  class servo_frame_scoreboard;
    logic [7:0]      identify_code;
    logic [7:0]      move_code;
    logic [15:0]     ident_word;
    bit              in_msg;
    int unsigned     word_count;
    logic [15:0]     msg_words [MSG_WORDS];
    deframe_result_t expected_results[$];
    int unsigned     words_seen;
    int unsigned     results_checked;
    int unsigned     errors;
    int unsigned     kind_hits [4];

    function new();
      identify_code = IDENTIFY_CODE_RST;
      move_code     = SERVO_MOVE_CODE_RST;
      ident_word    = IDENT_REPLY_RST;
      in_msg        = 0;
      word_count    = 0;
      foreach (msg_words[i]) msg_words[i] = '0;
    endfunction

    function void flag_error(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("ERROR: %s", msg);
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        REG_IDENTIFY_CODE:   identify_code = data[7:0];
        REG_SERVO_MOVE_CODE: move_code     = data[7:0];
        REG_IDENT_REPLY:     ident_word    = data[15:0];
        default: ;
      endcase
    endfunction

    function void add_result(kind_e k, logic [15:0] r, logic [4:0] idx, logic [7:0] v, bit l);
      deframe_result_t res;
      res.kind      = k;
      res.reply     = r;
      res.servo_idx = idx;
      res.servo_val = v;
      res.last      = l;
      expected_results.push_back(res);
    endfunction

    function void close_message();
      in_msg       = 0;
      word_count   = 0;
      msg_words[0] = '0;
    endfunction

    // Advance the framing state by one accepted word and queue its results
    function void predict_word(logic [15:0] w);
      logic [7:0]  cmd;
      int unsigned cnt;
      int unsigned n_payload;
      int unsigned offs;
      int unsigned wi;
      logic [15:0] src;
      logic [7:0]  b;
      words_seen++;
      if (!in_msg) begin
        msg_words[0] = w;
        if (w[15:8] == START_MARK) begin
          in_msg     = 1;
          word_count = 1;
        end else begin
          word_count = 0;
        end
      end else if (word_count < MSG_WORDS) begin
        msg_words[word_count] = w;
        word_count++;
      end
      if (!in_msg) return;

      cmd = msg_words[0][7:0];
      // identify wins when both codes are equal
      if (cmd == identify_code) begin
        add_result(KIND_REPLY, ident_word, '0, '0, 1'b1);
        close_message();
        return;
      end
      if (cmd == move_code && word_count > 2) begin
        cnt       = msg_words[1][7:0];
        offs      = msg_words[1][15:8];
        n_payload = (cnt + 1) / 2;
        if (word_count > n_payload + 1) begin
          if (offs + cnt > SERVO_BYTES) begin
            add_result(KIND_REJECT, '0, '0, '0, 1'b1);
          end else begin
            for (int unsigned i = 0; i < cnt; i++) begin
              wi  = 2 + i / 2;
              src = (wi < MSG_WORDS) ? msg_words[wi] : 16'h0000;
              b   = i[0] ? src[15:8] : src[7:0];
              add_result(KIND_BYTE, '0, 5'(offs + i), b, (i + 1 == cnt));
            end
          end
          close_message();
          return;
        end
      end
      // drop a message that fills the store without completing
      if (word_count >= MSG_WORDS) begin
        add_result(KIND_FULL, '0, '0, '0, 1'b1);
        close_message();
      end
    endfunction

    function void check_result(deframe_result_t got);
      deframe_result_t exp;
      if (expected_results.size() == 0) begin
        flag_error($sformatf("unexpected result kind=%0d reply=%h idx=%0d byte=%h last=%0d",
                             got.kind, got.reply, got.servo_idx, got.servo_val, got.last));
        return;
      end
      exp = expected_results.pop_front();
      results_checked++;
      kind_hits[got.kind]++;
      if (got.kind !== exp.kind || got.reply !== exp.reply ||
          got.servo_idx !== exp.servo_idx || got.servo_val !== exp.servo_val ||
          got.last !== exp.last)
        flag_error($sformatf({"result %0d: exp kind=%0d reply=%h idx=%0d byte=%h last=%0d,",
                              " got kind=%0d reply=%h idx=%0d byte=%h last=%0d"},
                             results_checked, exp.kind, exp.reply, exp.servo_idx,
                             exp.servo_val, exp.last, got.kind, got.reply, got.servo_idx,
                             got.servo_val, got.last));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [15:0] rx_word_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  kind_o;
  logic [15:0] reply_word_o;
  logic [4:0]  servo_index_o;
  logic [7:0]  servo_byte_o;
  logic        last_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  servo_frame_scoreboard frame_sb;
  logic [15:0]           word_q[$];
  int unsigned           settings_run;
  int                    idle_cycles;
  int                    stall_left = 0;
  int                    stall_mode = 0;

  spi_servo_command_deframer #(
    .MSG_WORDS  (MSG_WORDS),
    .SERVO_BYTES(SERVO_BYTES)
  ) uut (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .rx_word_i    (rx_word_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .reply_word_o (reply_word_o),
    .servo_index_o(servo_index_o),
    .servo_byte_o (servo_byte_o),
    .last_o       (last_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk = ~clk;

  // Check every result transaction against the oldest prediction
  always @(posedge clk) begin
    deframe_result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.kind      = kind_e'(kind_o);
      got.reply     = reply_word_o;
      got.servo_idx = servo_index_o;
      got.servo_val = servo_byte_o;
      got.last      = last_o;
      frame_sb.check_result(got);
    end
  end

  // Stall the result side in stretches: none, light, heavy, periodic
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(10, 60);
    end
    stall_left--;
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 3) == 0);
      2:       out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= (stall_left % 3 == 0);
    endcase
  end

  // End the run when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Hold one word until it is taken, then predict its results
  task automatic send_word(input logic [15:0] w);
    in_valid_i <= 1'b1;
    rx_word_i  <= w;
    do @(posedge clk); while (in_stall_o);
    frame_sb.predict_word(w);
  endtask

  task automatic idle_gap(input int unsigned n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (frame_sb.expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Send queued words in bursts with random gaps, draining now and then
  task automatic send_all();
    int unsigned burst;
    while (word_q.size() != 0) begin
      burst = $urandom_range(1, 12);
      for (int unsigned i = 0; i < burst && word_q.size() != 0; i++)
        send_word(word_q.pop_front());
      if ($urandom_range(0, 29) == 0) drain_results();
      else if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 20));
    end
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    frame_sb.set_reg(idx, data);
  endtask

  task automatic apb_read(input logic [1:0] idx, input logic [31:0] exp);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== exp)
      frame_sb.flag_error($sformatf("register %0d read: exp %h got %h", idx, exp, prdata));
    if (pready !== 1'b1)
      frame_sb.flag_error($sformatf("register %0d read: pready low", idx));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_registers();
    apb_read(REG_IDENTIFY_CODE, {24'h0, frame_sb.identify_code});
    apb_read(REG_SERVO_MOVE_CODE, {24'h0, frame_sb.move_code});
    apb_read(REG_IDENT_REPLY, {16'h0, frame_sb.ident_word});
  endtask

  // Close any open message, wait out the block, then load new codes
  task automatic reconfigure(input logic [7:0] id_code, input logic [7:0] mv_code,
                             input logic [15:0] reply);
    while (frame_sb.in_msg) send_word(16'h0000);
    drain_results();
    apb_write(REG_IDENTIFY_CODE, {24'h0, id_code});
    apb_write(REG_SERVO_MOVE_CODE, {24'h0, mv_code});
    apb_write(REG_IDENT_REPLY, {16'h0, reply});
    check_registers();
    settings_run++;
  endtask

  task automatic queue_servo_move(input logic [7:0] cnt, input logic [7:0] offs,
                                  input int unsigned n_payload);
    word_q.push_back({START_MARK, frame_sb.move_code});
    word_q.push_back({offs, cnt});
    repeat (n_payload) word_q.push_back(16'($urandom));
  endtask

  // Mostly well-formed messages with random content, plus noise and broken ones
  task automatic queue_random_traffic(input int unsigned n_words);
    int unsigned base;
    int unsigned pick;
    int unsigned cnt;
    int unsigned offs;
    int unsigned lo;
    logic [7:0]  cmd;
    logic [15:0] w;
    base = word_q.size();
    while (word_q.size() - base < n_words) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        cnt  = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 24) : $urandom_range(0, 12);
        offs = $urandom_range(0, SERVO_BYTES - cnt);
        queue_servo_move(8'(cnt), 8'(offs), (cnt < 2) ? 1 : (cnt + 1) / 2);
      end else if (pick < 45) begin
        cnt  = $urandom_range(1, 36);
        lo   = (cnt > SERVO_BYTES) ? 0 : SERVO_BYTES + 1 - cnt;
        offs = $urandom_range(lo, 255);
        queue_servo_move(8'(cnt), 8'(offs), (cnt + 1) / 2);
      end else if (pick < 60) begin
        word_q.push_back({START_MARK, frame_sb.identify_code});
      end else if (pick < 72) begin
        repeat ($urandom_range(1, 3)) begin
          do w = 16'($urandom); while (w[15:8] == START_MARK);
          word_q.push_back(w);
        end
      end else if (pick < 77) begin
        do cmd = 8'($urandom);
        while (cmd == frame_sb.identify_code || cmd == frame_sb.move_code);
        word_q.push_back({START_MARK, cmd});
        repeat (MSG_WORDS - 1) word_q.push_back(16'($urandom));
      end else if (pick < 82) begin
        queue_servo_move(8'($urandom_range(37, 255)), 8'($urandom), MSG_WORDS - 2);
      end else if (pick < 92) begin
        queue_servo_move(8'($urandom), 8'($urandom), $urandom_range(0, 2));
      end else begin
        word_q.push_back(16'($urandom));
      end
    end
  endtask

  initial begin
    logic [7:0] code_a;
    logic [7:0] code_b;
    frame_sb     = new();
    settings_run = 1;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    rx_word_i   <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    repeat (8) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    check_registers();

    // Directed: noise, identify, zero count at the top offset, reject, full
    word_q.push_back(16'hFFFF);
    word_q.push_back({START_MARK, frame_sb.identify_code});
    queue_servo_move(8'd0, 8'(SERVO_BYTES), 1);
    queue_servo_move(8'd1, 8'hFF, 1);
    word_q.push_back({START_MARK, 8'hFF});
    repeat (MSG_WORDS - 1) word_q.push_back(16'($urandom));
    send_all();
    queue_random_traffic(20);
    send_all();

    // Random traffic under several code settings
    reconfigure(8'h00, 8'hFF, 16'hFFFF);
    queue_random_traffic(95);
    send_all();
    reconfigure(8'hFF, 8'h00, 16'h0000);
    queue_random_traffic(95);
    send_all();
    code_a = 8'($urandom);
    reconfigure(code_a, code_a, 16'($urandom));
    queue_random_traffic(60);
    send_all();
    code_a = 8'($urandom);
    do code_b = 8'($urandom); while (code_b == code_a);
    reconfigure(code_a, code_b, 16'($urandom));
    queue_random_traffic(95);
    send_all();

    drain_results();
    repeat (40) @(posedge clk);
    if (frame_sb.expected_results.size() != 0)
      frame_sb.flag_error($sformatf("%0d expected results never arrived",
                                    frame_sb.expected_results.size()));
    $display("Sent %0d words under %0d code settings, checked %0d results, %0d errors",
             frame_sb.words_seen, settings_run, frame_sb.results_checked, frame_sb.errors);
    $display("Result mix: reply %0d, byte write %0d, rejected %0d, discarded %0d",
             frame_sb.kind_hits[KIND_REPLY], frame_sb.kind_hits[KIND_BYTE],
             frame_sb.kind_hits[KIND_REJECT], frame_sb.kind_hits[KIND_FULL]);
    if (frame_sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
